// ===== rtl/swsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Single-wire sensor reader package
// Shared widths, register indexes and the structs that pass between the
// configuration block, the sequencer and the output stage.
// ----------------------------------------------------------------------------
package swsr_pkg;

    // Width of the tick counter used for all timed waits.
    localparam int TICK_COUNT_BITS = 16;

    // Field widths.
    localparam int START_LOW_BITS = 16;
    localparam int SAMPLE_DELAY_BITS = 8;
    localparam int BYTE_BITS = 8;
    localparam int FRAME_BITS = 2 * BYTE_BITS;

    // Number of data bits in one read.
    localparam int NUM_BITS = 16;
    localparam int BIT_COUNT_BITS = 5;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_LOW_TICKS = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_DELAY_TICKS = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [START_LOW_BITS-1:0] START_LOW_RESET = 16'd20000;
    localparam logic [SAMPLE_DELAY_BITS-1:0] SAMPLE_DELAY_RESET = 8'd30;

    // Stream word widths.
    localparam int S_TDATA_BITS = 8;
    localparam int RESULT_BITS = 3 + FRAME_BITS;
    localparam int M_TDATA_BITS = 24;

    // Largest value the tick counter can hold, kept 32 bits wide for compares.
    localparam logic [31:0] TICK_MAX = (32'd1 << TICK_COUNT_BITS) - 32'd1;

    typedef logic [TICK_COUNT_BITS-1:0] tick_t;

    // Current configuration as seen by the sequencer.
    typedef struct packed {
        logic [START_LOW_BITS-1:0]    start_low_ticks;
        logic [SAMPLE_DELAY_BITS-1:0] sample_delay_ticks;
    } cfg_t;

    // One result word, fields from the highest bit down when packed to tdata.
    typedef struct packed {
        logic [BYTE_BITS-1:0] second_byte;
        logic [BYTE_BITS-1:0] first_byte;
        logic                 done_res;
        logic                 busy_res;
        logic                 drive_low;
    } result_t;

    // Clamp a wait threshold to what the tick counter can reach.
    function automatic tick_t clamp_limit(input logic [START_LOW_BITS-1:0] value);
        logic [31:0] wide;
        wide = 32'(value);
        if (wide > TICK_MAX) begin
            return tick_t'(TICK_MAX);
        end
        return wide[TICK_COUNT_BITS-1:0];
    endfunction

endpackage

// ===== rtl/swsr_cfg.sv =====
// ----------------------------------------------------------------------------
// Single-wire sensor reader configuration registers
// Holds the start pulse length and the bit sample delay, written through
// the configuration channel.
// ----------------------------------------------------------------------------
module swsr_cfg
    import swsr_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                      cfg
);

    logic [START_LOW_BITS-1:0]    start_low_reg;
    logic [SAMPLE_DELAY_BITS-1:0] sample_delay_reg;

    // Writes are always taken; an index outside the register list is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_low_reg    <= START_LOW_RESET;
            sample_delay_reg <= SAMPLE_DELAY_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_START_LOW_TICKS) begin
                start_low_reg <= cfg_data[START_LOW_BITS-1:0];
            end
            if (cfg_index == REG_SAMPLE_DELAY_TICKS) begin
                sample_delay_reg <= cfg_data[SAMPLE_DELAY_BITS-1:0];
            end
        end
    end

    assign cfg.start_low_ticks    = start_low_reg;
    assign cfg.sample_delay_ticks = sample_delay_reg;

endmodule

// ===== rtl/swsr_fsm.sv =====
// ----------------------------------------------------------------------------
// Single-wire sensor reader sequencer
// Steps the read sequence by one input word (tick or start) and forms the
// status result from the state after that step.
// ----------------------------------------------------------------------------
module swsr_fsm
    import swsr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_take,
    input  logic    command,
    input  logic    pin_level,
    input  cfg_t    cfg,
    output result_t result
);

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_START     = 3'd1;
    localparam logic [2:0] PH_RELEASE   = 3'd2;
    localparam logic [2:0] PH_RESP_LOW  = 3'd3;
    localparam logic [2:0] PH_RESP_HIGH = 3'd4;
    localparam logic [2:0] PH_WAIT_RISE = 3'd5;
    localparam logic [2:0] PH_DELAY     = 3'd6;
    localparam logic [2:0] PH_WAIT_FALL = 3'd7;

    logic [2:0]                phase_reg, phase_next;
    tick_t                     tick_reg, tick_next;
    logic [BIT_COUNT_BITS-1:0] bit_count_reg, bit_count_next;
    logic [FRAME_BITS-1:0]     shift_reg, shift_next;
    logic [FRAME_BITS-1:0]     bytes_reg, bytes_next;
    logic                      done;

    tick_t tick_inc;
    tick_t start_limit;
    tick_t delay_limit;

    // Saturating tick count and the clamped wait thresholds.
    assign tick_inc    = (tick_reg == tick_t'(TICK_MAX)) ? tick_reg : tick_reg + tick_t'(1);
    assign start_limit = clamp_limit(cfg.start_low_ticks);
    assign delay_limit = clamp_limit(START_LOW_BITS'(cfg.sample_delay_ticks));

    // Next state for one word.
    always_comb begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        bytes_next     = bytes_reg;
        done           = 1'b0;
        if (command) begin
            if (phase_reg == PH_IDLE) begin
                phase_next     = PH_START;
                tick_next      = '0;
                bit_count_next = '0;
                shift_next     = '0;
            end
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                end
                PH_START: begin
                    tick_next = tick_inc;
                    if (tick_inc >= start_limit) begin
                        phase_next = PH_RELEASE;
                    end
                end
                PH_RELEASE: begin
                    if (!pin_level) begin
                        phase_next = PH_RESP_LOW;
                    end else begin
                        // Line already high: the first bit's delay starts now.
                        phase_next = PH_DELAY;
                        tick_next  = '0;
                    end
                end
                PH_RESP_LOW: begin
                    if (pin_level) begin
                        phase_next = PH_RESP_HIGH;
                    end
                end
                PH_RESP_HIGH: begin
                    if (!pin_level) begin
                        phase_next = PH_WAIT_RISE;
                    end
                end
                PH_WAIT_RISE: begin
                    if (pin_level) begin
                        phase_next = PH_DELAY;
                        tick_next  = '0;
                    end
                end
                PH_DELAY: begin
                    tick_next = tick_inc;
                    if (tick_inc >= delay_limit) begin
                        shift_next     = {shift_reg[FRAME_BITS-2:0], pin_level};
                        bit_count_next = bit_count_reg + BIT_COUNT_BITS'(1);
                        phase_next     = PH_WAIT_FALL;
                    end
                end
                PH_WAIT_FALL: begin
                    if (!pin_level) begin
                        if (bit_count_reg >= BIT_COUNT_BITS'(NUM_BITS)) begin
                            bytes_next = shift_reg;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end else begin
                            phase_next = PH_WAIT_RISE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // State advances only on an accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_count_reg <= '0;
            shift_reg     <= '0;
            bytes_reg     <= '0;
        end else if (in_take) begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            bytes_reg     <= bytes_next;
        end
    end

    // Status after the step.
    assign result.drive_low   = (phase_next == PH_START);
    assign result.busy_res    = (phase_next != PH_IDLE);
    assign result.done_res    = done;
    assign result.first_byte  = bytes_next[FRAME_BITS-1:BYTE_BITS];
    assign result.second_byte = bytes_next[BYTE_BITS-1:0];

endmodule

// ===== rtl/swsr_out_skid.sv =====
// ----------------------------------------------------------------------------
// Single-wire sensor reader output stage
// Result register with a skid entry, so the input side's ready comes from a
// register and a word is taken while the previous result waits.
// ----------------------------------------------------------------------------
module swsr_out_skid
    import swsr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg;
    result_t main_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    // Control: main register refills from the skid entry first.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (!main_valid_reg || out_ready) begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end else if (push) begin
            skid_data_reg <= push_data;
        end
    end

endmodule

// ===== rtl/single_wire_sensor_reader.sv =====
// ----------------------------------------------------------------------------
// Single-wire sensor reader
// Tick-driven reader for a one-wire humidity sensor.
// ----------------------------------------------------------------------------
// Each word on the s_ channel is one timer tick (tuser 0) or a start request
// (tuser 1), with the sampled line level in tdata bit 0. Every accepted word
// gives exactly one result word on the m_ channel, carrying the line drive,
// busy and done flags and the two bytes of the last completed read.
// A start is honored only while idle; the line is pulled low for
// start_low_ticks ticks, then the response and 16 data bits are decoded, a
// bit sampled sample_delay_ticks ticks after each rising edge.
// Throughput is one word per clock while s_tready is high; the sequencer
// steps once per word and its result is registered in the output stage.
// A two-entry output stage keeps s_tready high while one result waits; when
// the receiver stalls, s_tready drops once the second entry is full and no
// word is lost. Synchronous reset returns the sequencer to idle, clears the
// bytes, empties the output stage and loads the register reset values.
// The cfg_ channel is always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module single_wire_sensor_reader
    import swsr_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    // Configuration write channel.
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    // Input words.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [S_TDATA_BITS-1:0]   s_tdata,   // [0] pin_level, [7:1] zero
    input  logic                      s_tuser,   // [0] command
    // Result words.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [10:3] first_byte,
    // [18:11] second_byte, [23:19] zero
    output logic [M_TDATA_BITS-1:0]   m_tdata
);

    cfg_t    cfg;
    result_t step_result;
    result_t out_result;
    logic    in_take;

    assign in_take = s_tvalid && s_tready;

    swsr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    swsr_fsm u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_take   (in_take),
        .command   (s_tuser),
        .pin_level (s_tdata[0]),
        .cfg       (cfg),
        .result    (step_result)
    );

    swsr_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_take),
        .push_data (step_result),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = M_TDATA_BITS'(out_result);

endmodule

// ===== rtl/swsr_checker.sv =====
// ----------------------------------------------------------------------------
// Single-wire sensor reader checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module swsr_checker
    import swsr_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [M_TDATA_BITS-1:0] m_tdata
);

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // A completed read leaves the block idle and the line released.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> !m_tdata[1] && !m_tdata[0])
        else $error("done reported while busy or driving");

    // Driving the line only happens inside a read.
    a_drive_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[1])
        else $error("line driven while not busy");

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind single_wire_sensor_reader swsr_checker u_swsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Single-wire sensor reader testbench
// Drives tick and start words with a scripted line level, predicts every
// result word, and compares the flags and both bytes field by field.
// ----------------------------------------------------------------------------
// Start pulses begin at the reset register values and at the largest
// thresholds, and a smaller setting written while idle of traffic cuts each
// one short. Full reads then run at zero thresholds, at the smallest legal
// ones and at many small random settings. Most reads follow the sensor
// protocol with random data; some begin with the line already high, some are
// cut short and then driven through to idle, and start words land at random
// while a read is in progress. Both sides of the stream insert random gaps,
// with two stretches free of them.
// ----------------------------------------------------------------------------
import swsr_pkg::*;

typedef enum bit {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
} command_e;

typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_START,
    SEQ_RELEASE,
    SEQ_RESP_LOW,
    SEQ_RESP_HIGH,
    SEQ_WAIT_RISE,
    SEQ_DELAY,
    SEQ_WAIT_FALL
} seq_phase_e;

// Tracks the reader state, holds the result words still owed and checks
// each one that arrives.
class swsr_scoreboard;
    localparam int REPORT_LIMIT = 100;

    seq_phase_e                 phase;
    bit [TICK_COUNT_BITS-1:0]   tick_count;
    bit [BIT_COUNT_BITS-1:0]    bit_count;
    bit [FRAME_BITS-1:0]        shift_bits;
    bit [FRAME_BITS-1:0]        result_bytes;
    bit [START_LOW_BITS-1:0]    start_low;
    bit [SAMPLE_DELAY_BITS-1:0] sample_delay;
    result_t                    owed_words[$];

    int unsigned words;
    int unsigned reads_done;
    int unsigned ignored_starts;
    int unsigned idle_ticks;
    int unsigned early_releases;
    int unsigned failures;

    function new();
        phase = SEQ_IDLE;
        tick_count = '0;
        bit_count = '0;
        shift_bits = '0;
        result_bytes = '0;
        start_low = START_LOW_RESET;
        sample_delay = SAMPLE_DELAY_RESET;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] index,
                            logic [CFG_DATA_BITS-1:0] value);
        case (index)
            REG_START_LOW_TICKS: begin
                start_low = value;
            end
            REG_SAMPLE_DELAY_TICKS: begin
                sample_delay = value[SAMPLE_DELAY_BITS-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    // Advance the tick counter, saturating, and report whether the wait is over.
    function bit count_to(int unsigned threshold);
        int unsigned ceiling;
        ceiling = (threshold > TICK_MAX) ? TICK_MAX : threshold;
        if (32'(tick_count) < TICK_MAX) begin
            tick_count = tick_count + 1'b1;
        end
        return 32'(tick_count) >= ceiling;
    endfunction

    function void note_input(command_e cmd, bit pin);
        result_t owed;
        bit      done;
        done = 1'b0;
        words++;
        if (cmd == CMD_START) begin
            if (phase == SEQ_IDLE) begin
                phase = SEQ_START;
                tick_count = '0;
                bit_count = '0;
                shift_bits = '0;
            end else begin
                ignored_starts++;
            end
        end else begin
            case (phase)
                SEQ_IDLE: begin
                    idle_ticks++;
                end
                SEQ_START: begin
                    if (count_to(32'(start_low))) phase = SEQ_RELEASE;
                end
                SEQ_RELEASE: begin
                    // A high line at release skips the response entirely.
                    if (!pin) begin
                        phase = SEQ_RESP_LOW;
                    end else begin
                        phase = SEQ_DELAY;
                        tick_count = '0;
                        early_releases++;
                    end
                end
                SEQ_RESP_LOW: begin
                    if (pin) phase = SEQ_RESP_HIGH;
                end
                SEQ_RESP_HIGH: begin
                    if (!pin) phase = SEQ_WAIT_RISE;
                end
                SEQ_WAIT_RISE: begin
                    if (pin) begin
                        phase = SEQ_DELAY;
                        tick_count = '0;
                    end
                end
                SEQ_DELAY: begin
                    if (count_to(32'(sample_delay))) begin
                        shift_bits = {shift_bits[FRAME_BITS-2:0], pin};
                        bit_count = bit_count + 1'b1;
                        phase = SEQ_WAIT_FALL;
                    end
                end
                SEQ_WAIT_FALL: begin
                    if (!pin) begin
                        if (bit_count >= NUM_BITS) begin
                            result_bytes = shift_bits;
                            phase = SEQ_IDLE;
                            done = 1'b1;
                            reads_done++;
                        end else begin
                            phase = SEQ_WAIT_RISE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        owed.drive_low = (phase == SEQ_START);
        owed.busy_res = (phase != SEQ_IDLE);
        owed.done_res = done;
        owed.first_byte = result_bytes[FRAME_BITS-1:BYTE_BITS];
        owed.second_byte = result_bytes[BYTE_BITS-1:0];
        owed_words.push_back(owed);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
                $error("%s: expected %0d, got %0d", field, want, got);
            end
        end
    endfunction

    function void check_result(logic [M_TDATA_BITS-1:0] word);
        result_t got;
        result_t want;
        got = word[RESULT_BITS-1:0];
        if (owed_words.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
                $error("result word %h arrived with none outstanding", word);
            end
            return;
        end
        want = owed_words.pop_front();
        compare_field("drive_low", 8'(want.drive_low), 8'(got.drive_low));
        compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
        compare_field("first_byte", want.first_byte, got.first_byte);
        compare_field("second_byte", want.second_byte, got.second_byte);
        compare_field("padding", '0, 8'(word[M_TDATA_BITS-1:RESULT_BITS]));
    endfunction

    function int unsigned pending();
        return owed_words.size();
    endfunction

    function bit busy();
        return phase != SEQ_IDLE;
    endfunction

    function bit starting();
        return phase == SEQ_START;
    endfunction
endclass

module tb_top;
    localparam int IDLE_PERCENT = 9;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 4;
    localparam int WORD_TARGET = 1000;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [S_TDATA_BITS-1:0]   s_tdata = '0;
    logic                      s_tuser = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0]   m_tdata;

    swsr_scoreboard sb = new();

    bit                         steady = 1'b0;
    bit [START_LOW_BITS-1:0]    cur_start_low = START_LOW_RESET;
    bit [SAMPLE_DELAY_BITS-1:0] cur_delay = SAMPLE_DELAY_RESET;
    int unsigned                settings_used = 1;
    int unsigned                recoveries = 0;
    int unsigned                quiet_cycles = 0;

    always #1 aclk = ~aclk;

    single_wire_sensor_reader uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Receiver backpressure.
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Watch every handshake: register writes, input words and result words.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) sb.note_input(command_e'(s_tuser), s_tdata[0]);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    // Count cycles in which nothing moves on any channel.
    always @(posedge aclk) begin
        if (!aresetn || (cfg_valid && cfg_ready) || (s_tvalid && s_tready) ||
            (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Watchdog: no word moved for %0d cycles.", WATCHDOG_LIMIT);
        $display("single_wire_sensor_reader: mismatch");
        $finish;
    end

    // Present one word, with a random gap ahead of it, and wait until taken.
    task automatic send_word(command_e cmd, bit pin);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {{(S_TDATA_BITS-1){1'b0}}, pin};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold off the sender until every owed result word has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write both registers once no word is in flight.
    task automatic apply_settings(bit [CFG_DATA_BITS-1:0] low_ticks,
                                  bit [CFG_DATA_BITS-1:0] delay_word);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= REG_START_LOW_TICKS;
        cfg_data <= low_ticks;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= REG_SAMPLE_DELAY_TICKS;
        cfg_data <= delay_word;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_start_low = low_ticks;
        cur_delay = delay_word[SAMPLE_DELAY_BITS-1:0];
        settings_used++;
    endtask

    // Push a stuck read through to idle: finish the start pulse, then pulse
    // the line with highs long enough to cover the sample delay.
    task automatic recover();
        int unsigned n;
        drain();
        if (sb.busy()) begin
            if (sb.starting()) begin
                n = (cur_start_low == 0) ? 1 : cur_start_low;
                repeat (n) send_word(CMD_TICK, 1'($urandom_range(1)));
            end
            repeat (FRAME_BITS + 2) begin
                send_word(CMD_TICK, 1'b0);
                repeat (cur_delay + 2) send_word(CMD_TICK, 1'b1);
            end
            send_word(CMD_TICK, 1'b0);
            recoveries++;
        end
    endtask

    // One read as the sensor would answer it, timed from the current
    // settings. A non-negative cut stops after that many ticks.
    task automatic play_read(bit [FRAME_BITS-1:0] data, bit early_high,
                             bit extra_start, int cut);
        bit          pins[$];
        int unsigned n;
        send_word(CMD_START, 1'($urandom_range(1)));
        if (extra_start) send_word(CMD_START, 1'($urandom_range(1)));
        n = (cur_start_low == 0) ? 1 : cur_start_low;
        repeat (n) pins.push_back(1'($urandom_range(1)));
        pins.push_back(early_high);
        // Sensor response: a low part, then a high part.
        if (!early_high) begin
            repeat ($urandom_range(2)) pins.push_back(1'b0);
            pins.push_back(1'b1);
            repeat ($urandom_range(2)) pins.push_back(1'b1);
            pins.push_back(1'b0);
        end
        // Data bits, most significant first; the level on the last tick of
        // the delay is the one sampled.
        for (int i = FRAME_BITS - 1; i >= 0; i--) begin
            if (!(early_high && i == FRAME_BITS - 1)) begin
                repeat ($urandom_range(2)) pins.push_back(1'b0);
                pins.push_back(1'b1);
            end
            n = (cur_delay == 0) ? 1 : cur_delay;
            repeat (n - 1) pins.push_back(1'($urandom_range(1)));
            pins.push_back(data[i]);
            repeat ($urandom_range(2)) pins.push_back(1'b1);
            pins.push_back(1'b0);
        end
        n = (cut >= 0 && cut < pins.size()) ? cut : pins.size();
        for (int j = 0; j < n; j++) begin
            if ($urandom_range(24) == 0) send_word(CMD_START, 1'($urandom_range(1)));
            send_word(CMD_TICK, pins[j]);
        end
        if (n < pins.size()) recover();
    endtask

    initial begin : stimulus
        int unsigned phase_count;
        int          cut;
        bit [CFG_DATA_BITS-1:0] low_ticks;
        bit [SAMPLE_DELAY_BITS-1:0] delay;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Ticks while idle, then a start pulse at the reset register values
        // that a shorter setting ends early.
        send_word(CMD_TICK, 1'b0);
        send_word(CMD_TICK, 1'b1);
        send_word(CMD_START, 1'b1);
        send_word(CMD_START, 1'b0);
        repeat (20) send_word(CMD_TICK, 1'($urandom_range(1)));
        apply_settings(16'd3, 16'd2);
        recover();

        // Zero thresholds: each wait ends on its first tick.
        apply_settings('0, '0);
        play_read('0, 1'b1, 1'b1, -1);
        play_read(16'h5AA5, 1'b0, 1'b0, -1);
        play_read(16'($urandom), 1'b0, 1'b0, $urandom_range(3, 40));

        // Largest thresholds, with no gaps on either side: part of a long
        // start pulse, then a full longest sample delay after a high release.
        apply_settings({CFG_DATA_BITS{1'b1}}, {CFG_DATA_BITS{1'b1}});
        steady = 1'b1;
        send_word(CMD_START, 1'b0);
        repeat (20) send_word(CMD_TICK, 1'($urandom_range(1)));
        apply_settings(16'd1, {CFG_DATA_BITS{1'b1}});
        send_word(CMD_TICK, 1'b1);
        send_word(CMD_TICK, 1'b1);
        repeat (258) send_word(CMD_TICK, 1'b1);
        steady = 1'b0;
        apply_settings(16'd2, 16'd1);
        recover();

        // Smallest legal thresholds; junk in the unused register bits.
        apply_settings(16'd1, {8'($urandom), 8'd1});
        play_read(16'($urandom), 1'b1, 1'b0, -1);
        play_read(16'($urandom), 1'b0, 1'b0, -1);

        // Random settings, mostly short, each with a few reads.
        phase_count = 0;
        while (sb.words < WORD_TARGET) begin
            low_ticks = ($urandom_range(5) == 0) ? '0 : 16'($urandom_range(1, 24));
            delay = ($urandom_range(5) == 0) ? '0 : 8'($urandom_range(1, 5));
            apply_settings(low_ticks, {8'($urandom), delay});
            steady = (phase_count == 2);
            repeat ($urandom_range(2, 4)) begin
                if (sb.words >= WORD_TARGET) break;
                repeat ($urandom_range(3)) send_word(CMD_TICK, 1'($urandom_range(1)));
                cut = ($urandom_range(7) == 0) ? int'($urandom_range(1, 60)) : -1;
                play_read(16'($urandom), $urandom_range(5) == 0, $urandom_range(3) == 0,
                          cut);
            end
            phase_count++;
        end
        steady = 1'b0;

        drain();
        $display("Run covered %0d words over %0d register settings: %0d reads done,",
                 sb.words, settings_used, sb.reads_done);
        $display("%0d with the line high at release, %0d cut short, %0d busy starts.",
                 sb.early_releases, recoveries, sb.ignored_starts);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("single_wire_sensor_reader: match");
        end else begin
            $display("single_wire_sensor_reader: mismatch");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/swsr_pkg.sv
rtl/swsr_cfg.sv
rtl/swsr_fsm.sv
rtl/swsr_out_skid.sv
rtl/single_wire_sensor_reader.sv
rtl/swsr_checker.sv
sim/tb_top.sv
